@@ hw/rtl/etfp_pkg.sv @@
// ---------------------------------------------------------------------------
// etfp_pkg
// Shared types, constants and register indexes for the escape-time fractal
// pixel evaluator.
// ---------------------------------------------------------------------------
package etfp_pkg;

   localparam int PIX_BITS  = 12;
   localparam int ITER_BITS = 16;
   localparam int FRAC_BITS = 26;

   // register indexes
   localparam logic [2:0] REG_RE_ORIGIN = 3'd0;
   localparam logic [2:0] REG_RE_STEP   = 3'd1;
   localparam logic [2:0] REG_IM_ORIGIN = 3'd2;
   localparam logic [2:0] REG_IM_STEP   = 3'd3;
   localparam logic [2:0] REG_ITER_LIM  = 3'd4;
   localparam logic [2:0] REG_KIND      = 3'd5;
   localparam logic [2:0] REG_JULIA_RE  = 3'd6;
   localparam logic [2:0] REG_JULIA_IM  = 3'd7;

   // fractal kinds
   localparam logic [1:0] KIND_MANDEL = 2'd0;
   localparam logic [1:0] KIND_JULIA  = 2'd1;
   localparam logic [1:0] KIND_SHIP   = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   // back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD,
      ST_SQRT,
      ST_DIV,
      ST_DONE
   } be_state_type;

   // work item from front to back: starting z and c
   typedef struct packed {
      logic        kill;
      logic        ship;
      logic [31:0] zr;
      logic [31:0] zi;
      logic [31:0] cr;
      logic [31:0] ci;
   } work_type;

   // saturate a 46-bit signed sum to 32 bits
   function automatic logic [31:0] sat32(input logic signed [45:0] v);
      logic [31:0] r;
      if (v > 46'sd2147483647)       r = 32'h7FFF_FFFF;
      else if (v < -46'sd2147483648) r = 32'h8000_0000;
      else                           r = v[31:0];
      return r;
   endfunction

endpackage

@@ hw/rtl/etfp_front.sv @@
// ---------------------------------------------------------------------------
// etfp_front
// Accepts pixel requests, maps them to the complex plane and forms the
// starting z and c for the selected kind. Two registered stages.
// ---------------------------------------------------------------------------
module etfp_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [etfp_pkg::PIX_BITS-1:0]    col,
   input  logic [etfp_pkg::PIX_BITS-1:0]    row,
   input  logic [31:0]                      re_origin,
   input  logic [30:0]                      re_step,
   input  logic [31:0]                      im_origin,
   input  logic [30:0]                      im_step,
   input  logic [1:0]                       kind,
   input  logic [31:0]                      julia_re,
   input  logic [31:0]                      julia_im,
   output logic                             out_valid,
   input  logic                             out_ready,
   output etfp_pkg::work_type               out_work
);

   // stage 1: products
   logic        s1_v_ff, s1_v_in;
   logic [42:0] pr_prod_ff, pi_prod_ff;
   // stage 2: work item
   logic        s2_v_ff, s2_v_in;
   etfp_pkg::work_type s2_ff, s2_in;
   logic [31:0] pr, pi, pin;
   logic        adv2, adv1;

   assign adv2     = !s2_v_ff || out_ready;
   assign adv1     = !s1_v_ff || adv2;
   assign in_ready = adv1;

   always_comb begin
      s1_v_in = adv1 ? in_valid : s1_v_ff;
      s2_v_in = adv2 ? s1_v_ff : s2_v_ff;
   end

   // point coordinates and starting values
   always_comb begin
      pr  = etfp_pkg::sat32(46'($signed(re_origin)) + 46'($signed({1'b0, pr_prod_ff})));
      pi  = etfp_pkg::sat32(46'($signed(im_origin)) + 46'($signed({1'b0, pi_prod_ff})));
      pin = etfp_pkg::sat32(-46'($signed(pi)));
      s2_in      = s2_ff;
      s2_in.kill = (kind == etfp_pkg::KIND_NONE);
      s2_in.ship = (kind == etfp_pkg::KIND_SHIP);
      if (kind == etfp_pkg::KIND_JULIA) begin
         s2_in.zr = pr;
         s2_in.zi = pi;
         s2_in.cr = julia_re;
         s2_in.ci = julia_im;
      end else begin
         s2_in.zr = '0;
         s2_in.zi = '0;
         s2_in.cr = pr;
         s2_in.ci = (kind == etfp_pkg::KIND_SHIP) ? pin : pi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
      if (adv1 && in_valid) begin
         pr_prod_ff <= 43'(col) * 43'(re_step);
         pi_prod_ff <= 43'(row) * 43'(im_step);
      end
      if (adv2 && s1_v_ff) s2_ff <= s2_in;
   end

   assign out_valid = s2_v_ff;
   assign out_work  = s2_ff;

endmodule

@@ hw/rtl/etfp_queue.sv @@
// ---------------------------------------------------------------------------
// etfp_queue
// Two-entry queue of work items between front and back.
// ---------------------------------------------------------------------------
module etfp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  etfp_pkg::work_type in_work,
   output logic               out_valid,
   input  logic               out_ready,
   output etfp_pkg::work_type out_work
);

   etfp_pkg::work_type mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_work  = mem_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_work;
   end

`ifndef SYNTH
   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   a_full_no_push: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> cnt_ff == 2'd2)
      else $error("queue lost an entry");
   a_empty_stays: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 && !push) |=> cnt_ff == 2'd0)
      else $error("queue invented an entry");
`endif

endmodule

@@ hw/rtl/etfp_back.sv @@
// ---------------------------------------------------------------------------
// etfp_back
// Iterates z <- z^2 + c on one shared multiplier set, then computes the two
// magnitudes by a bit-pair square root and the fraction by restoring division.
// ---------------------------------------------------------------------------
module etfp_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  etfp_pkg::work_type              in_work,
   input  logic [etfp_pkg::ITER_BITS-1:0]  limit,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic                            out_inside,
   output logic [etfp_pkg::ITER_BITS-1:0]  out_count,
   output logic [15:0]                     out_frac
);

   localparam logic [63:0] ESC_SQ = 64'd4 << (2 * etfp_pkg::FRAC_BITS);
   localparam logic [32:0] TWO_Q  = 33'd2 << etfp_pkg::FRAC_BITS;

   etfp_pkg::be_state_type st_ff, st_in;
   etfp_pkg::work_type     w_ff;
   logic [31:0] vr_ff, vi_ff;
   logic [etfp_pkg::ITER_BITS-1:0] it_ff;
   logic signed [63:0] rr_ff, ii_ff, ri_ff;
   // square root: two radicands worked in parallel
   logic [63:0] sx_ff [2];
   logic [63:0] sres_ff [2];
   logic [5:0]  sstep_ff;
   // divider
   logic [48:0] num_ff;
   logic [32:0] den_ff;
   logic [33:0] rem_ff;
   logic [5:0]  dstep_ff;
   logic        res_inside_ff, res_zero_ff;
   logic [etfp_pkg::ITER_BITS-1:0] res_cnt_ff;
   logic [15:0] res_frac_ff;

   logic signed [31:0] ar, ai;
   logic [63:0] cur_msq, prev_msq;
   logic        escaped, at_lim;
   logic [31:0] nzr, nzi;
   logic [33:0] rem_sh;
   logic [63:0] bitv;

   assign in_ready  = (st_ff == etfp_pkg::ST_IDLE);
   assign out_valid = (st_ff == etfp_pkg::ST_DONE);
   assign out_inside = res_inside_ff;
   assign out_count  = res_cnt_ff;
   assign out_frac   = res_frac_ff;

   function automatic logic [31:0] absv(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [63:0] msq(input logic [31:0] r, input logic [31:0] i);
      logic [31:0] a, b;
      a = absv(r);
      b = absv(i);
      return 64'(a) * 64'(a) + 64'(b) * 64'(b);
   endfunction

   always_comb begin
      ar = w_ff.ship ? $signed(absv(w_ff.zr)) : $signed(w_ff.zr);
      ai = w_ff.ship ? $signed(absv(w_ff.zi)) : $signed(w_ff.zi);
      cur_msq  = msq(w_ff.zr, w_ff.zi);
      escaped  = (cur_msq >= ESC_SQ);
      at_lim   = (it_ff == limit);
      nzr = etfp_pkg::sat32(46'(rr_ff - ii_ff >>> etfp_pkg::FRAC_BITS)
                            + 46'($signed(w_ff.cr)));
      nzi = etfp_pkg::sat32(46'((ri_ff <<< 1) >>> etfp_pkg::FRAC_BITS)
                            + 46'($signed(w_ff.ci)));
      prev_msq = msq(vr_ff, vi_ff);
      rem_sh   = {rem_ff[32:0], num_ff[48]};
      bitv     = 64'd1 << {sstep_ff[4:0], 1'b0};
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         etfp_pkg::ST_IDLE: if (in_valid) st_in = etfp_pkg::ST_UPD;
         etfp_pkg::ST_UPD:
            if (w_ff.kill || escaped || at_lim) begin
               if (w_ff.kill || at_lim) st_in = etfp_pkg::ST_DONE;
               else st_in = etfp_pkg::ST_SQRT;
            end else st_in = etfp_pkg::ST_MUL;
         etfp_pkg::ST_MUL:  st_in = etfp_pkg::ST_UPD;
         etfp_pkg::ST_SQRT: if (sstep_ff == 6'd0) st_in = etfp_pkg::ST_DIV;
         etfp_pkg::ST_DIV:  if (res_zero_ff || dstep_ff == 6'd0) st_in = etfp_pkg::ST_DONE;
         etfp_pkg::ST_DONE: if (out_ready) st_in = etfp_pkg::ST_IDLE;
         default:           st_in = etfp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= etfp_pkg::ST_IDLE;
      else       st_ff <= st_in;
   end

   // datapath
   always_ff @(posedge clock) begin
      case (st_ff)
         etfp_pkg::ST_IDLE: if (in_valid) begin
            w_ff   <= in_work;
            vr_ff  <= in_work.zr;
            vi_ff  <= in_work.zi;
            it_ff  <= '0;
         end
         etfp_pkg::ST_UPD: begin
            if (w_ff.kill) begin
               res_inside_ff <= 1'b0;
               res_cnt_ff    <= '0;
               res_frac_ff   <= '0;
            end else if (at_lim) begin
               res_inside_ff <= 1'b1;
               res_cnt_ff    <= '0;
               res_frac_ff   <= '0;
            end else if (escaped) begin
               res_inside_ff <= 1'b0;
               res_cnt_ff    <= it_ff;
               sx_ff[0]      <= prev_msq;
               sx_ff[1]      <= cur_msq;
               sres_ff[0]    <= '0;
               sres_ff[1]    <= '0;
               sstep_ff      <= 6'd31;
            end else begin
               vr_ff <= w_ff.zr;
               vi_ff <= w_ff.zi;
               rr_ff <= 64'(ar) * 64'(ar);
               ii_ff <= 64'(ai) * 64'(ai);
               ri_ff <= 64'(ar) * 64'(ai);
            end
         end
         etfp_pkg::ST_MUL: begin
            w_ff.zr <= nzr;
            w_ff.zi <= nzi;
            it_ff   <= it_ff + 1'b1;
         end
         etfp_pkg::ST_SQRT: begin
            for (int k = 0; k < 2; k++) begin
               if (sx_ff[k] >= sres_ff[k] + bitv) begin
                  sx_ff[k]   <= sx_ff[k] - (sres_ff[k] + bitv);
                  sres_ff[k] <= (sres_ff[k] >> 1) + bitv;
               end else begin
                  sres_ff[k] <= sres_ff[k] >> 1;
               end
            end
            sstep_ff <= sstep_ff - 6'd1;
            if (sstep_ff == 6'd0) begin
               res_frac_ff <= '0;
               rem_ff      <= '0;
               dstep_ff    <= 6'd49;
               res_zero_ff <= 1'b0;
            end
         end
         etfp_pkg::ST_DIV: begin
            // sres now holds final magnitudes
            if (dstep_ff == 6'd49) begin
               // fraction only when the magnitude grew from below two
               if (sres_ff[1] > sres_ff[0] && sres_ff[0] < 64'(TWO_Q)) begin
                  num_ff   <= {(TWO_Q - sres_ff[0][32:0]), 16'd0};
                  den_ff   <= sres_ff[1][32:0] - sres_ff[0][32:0];
                  rem_ff   <= '0;
                  dstep_ff <= 6'd48;
               end else begin
                  res_zero_ff <= 1'b1;
               end
            end else if (!res_zero_ff) begin
               num_ff <= {num_ff[47:0], 1'b0};
               if (rem_sh >= 34'(den_ff)) begin
                  rem_ff <= rem_sh - 34'(den_ff);
                  if (res_frac_ff != 16'hFFFF) begin
                     if (dstep_ff > 6'd15) res_frac_ff <= 16'hFFFF;
                     else res_frac_ff <= {res_frac_ff[14:0], 1'b1};
                  end
               end else begin
                  rem_ff <= rem_sh;
                  if (res_frac_ff != 16'hFFFF && dstep_ff <= 6'd15)
                     res_frac_ff <= {res_frac_ff[14:0], 1'b0};
               end
               if (dstep_ff != 6'd0) dstep_ff <= dstep_ff - 6'd1;
            end
         end
         default: ;
      endcase
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (st_ff == etfp_pkg::ST_MUL) |-> (it_ff < limit))
      else $error("iteration beyond limit");
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (st_ff == etfp_pkg::ST_DONE && !out_ready) |=> st_ff == etfp_pkg::ST_DONE)
      else $error("result dropped");
   a_inside_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_inside) |-> (out_count == '0 && out_frac == '0))
      else $error("inside result carries count");
`endif

endmodule

@@ hw/rtl/escape_time_fractal_pixel.sv @@
// Path: front end and queue, then the iterations, the two square roots and the
// divide for an escaping pixel (the divide is cut short when the fraction is
// zero); an inside pixel goes straight to its result after the iterations.
// The back end works on one pixel at a time and takes the next only after the
// last result is accepted; the front end and queue hold up to four more requests.
// Reset: synchronous, active high; registers return to their reset values.
// ---------------------------------------------------------------------------
// escape_time_fractal_pixel
// Top level: configuration registers, front end, queue and iteration engine.
// ---------------------------------------------------------------------------
module escape_time_fractal_pixel (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pixel_col[11:0], pixel_row[23:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // inside_set[0], escape_count[16:1], smooth_fraction[32:17]
);

   logic [31:0] re_origin_ff, im_origin_ff, julia_re_ff, julia_im_ff;
   logic [30:0] re_step_ff, im_step_ff;
   logic [15:0] lim_ff;
   logic [1:0]  kind_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         re_origin_ff <= 32'hE000_0000;
         re_step_ff   <= 31'd524288;
         im_origin_ff <= 32'hE000_0000;
         im_step_ff   <= 31'd524288;
         lim_ff       <= 16'd100;
         kind_ff      <= etfp_pkg::KIND_MANDEL;
         julia_re_ff  <= '0;
         julia_im_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            etfp_pkg::REG_RE_ORIGIN: re_origin_ff <= csr_wdata;
            etfp_pkg::REG_RE_STEP:   re_step_ff   <= csr_wdata[30:0];
            etfp_pkg::REG_IM_ORIGIN: im_origin_ff <= csr_wdata;
            etfp_pkg::REG_IM_STEP:   im_step_ff   <= csr_wdata[30:0];
            etfp_pkg::REG_ITER_LIM:  lim_ff       <= csr_wdata[15:0];
            etfp_pkg::REG_KIND:      kind_ff      <= csr_wdata[1:0];
            etfp_pkg::REG_JULIA_RE:  julia_re_ff  <= csr_wdata;
            etfp_pkg::REG_JULIA_IM:  julia_im_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic               f_v, f_r, q_v, q_r;
   etfp_pkg::work_type f_w, q_w;
   logic               o_in;
   logic [15:0]        o_cnt, o_frac;

   etfp_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .col(req_tdata[11:0]), .row(req_tdata[23:12]),
      .re_origin(re_origin_ff), .re_step(re_step_ff),
      .im_origin(im_origin_ff), .im_step(im_step_ff),
      .kind(kind_ff), .julia_re(julia_re_ff), .julia_im(julia_im_ff),
      .out_valid(f_v), .out_ready(f_r), .out_work(f_w)
   );

   etfp_queue u_queue (
      .clock, .reset,
      .in_valid(f_v), .in_ready(f_r), .in_work(f_w),
      .out_valid(q_v), .out_ready(q_r), .out_work(q_w)
   );

   etfp_back u_back (
      .clock, .reset,
      .in_valid(q_v), .in_ready(q_r), .in_work(q_w), .limit(lim_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_inside(o_in), .out_count(o_cnt), .out_frac(o_frac)
   );

   assign rsp_tdata = {7'd0, o_frac, o_cnt, o_in};

endmodule

@@ verif/escape_time_fractal_pixel_tb.sv @@
// ---------------------------------------------------------------------------
// escape_time_fractal_pixel_tb
// Self-checking bench for the escape-time fractal pixel evaluator. Pixel
// requests go in on the req_ stream and each response is checked field by
// field against an escape-time predictor kept in the bench. The run covers
// directed corners, randomized views, backpressure and a full-limit pixel.
// ---------------------------------------------------------------------------
module escape_time_fractal_pixel_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned ESCAPE_SQ = 64'd4 << 52;
   localparam longint unsigned TWO_Q     = 64'd2 << 26;
   localparam int CYCLE_LIMIT = 5000000;

   typedef struct packed {
      logic        in_set;
      logic [15:0] count;
      logic [15:0] frac;
   } pix_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = etfp_pkg::REG_RE_ORIGIN;
   logic [31:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // pixel_col[11:0], pixel_row[23:12]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;       // inside_set[0], escape_count[16:1], smooth_fraction[32:17]

   // bench copy of the register file
   logic [31:0] cfg_re_origin = 32'hE000_0000;
   logic [30:0] cfg_re_step   = 31'd524288;
   logic [31:0] cfg_im_origin = 32'hE000_0000;
   logic [30:0] cfg_im_step   = 31'd524288;
   logic [15:0] cfg_limit     = 16'd100;
   logic [1:0]  cfg_kind      = etfp_pkg::KIND_MANDEL;
   logic [31:0] cfg_julia_re  = '0;
   logic [31:0] cfg_julia_im  = '0;

   pix_result_type pending_px[$];
   int  err_count = 0;
   int  cycle_count = 0;
   bit  tx_idle = 1'b0;
   bit  rx_idle = 1'b0;
   int  hold_len = 0;
   int  hold_seq = 0;
   int  hold_seen = 0;
   int  hold_cnt = 0;
   int  gap_cnt = 0;

   escape_time_fractal_pixel i_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------- predictor ----------------
   function automatic longint clamp_q(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned abs_q(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned norm_sq(longint re, longint im);
      longint unsigned a, b;
      a = abs_q(re);
      b = abs_q(im);
      return a * a + b * b;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic pix_result_type escape_pixel(logic [11:0] col, logic [11:0] row);
      longint pr, pi, zr, zi, cr, ci, vr, vi, ar, ai, sr, si;
      longint unsigned iters, mp, mc, frac;
      bit ship;
      pix_result_type r;
      r = '0;
      iters = 0;
      frac = 0;
      ship = (cfg_kind == etfp_pkg::KIND_SHIP);
      pr = clamp_q(longint'($signed(cfg_re_origin)) + longint'(col) * longint'(cfg_re_step));
      pi = clamp_q(longint'($signed(cfg_im_origin)) + longint'(row) * longint'(cfg_im_step));
      if (cfg_kind == etfp_pkg::KIND_NONE) return r;
      if (cfg_kind == etfp_pkg::KIND_JULIA) begin
         zr = pr; zi = pi;
         cr = longint'($signed(cfg_julia_re));
         ci = longint'($signed(cfg_julia_im));
      end else begin
         zr = 0; zi = 0;
         cr = pr;
         ci = ship ? clamp_q(-pi) : pi;
      end
      vr = zr; vi = zi;
      while (norm_sq(zr, zi) < ESCAPE_SQ && iters < cfg_limit) begin
         vr = zr; vi = zi;
         ar = ship ? longint'(abs_q(zr)) : zr;
         ai = ship ? longint'(abs_q(zi)) : zi;
         sr = ar * ar - ai * ai;
         si = 2 * ar * ai;
         zr = clamp_q((sr >>> 26) + cr);
         zi = clamp_q((si >>> 26) + ci);
         iters++;
      end
      if (iters == cfg_limit) begin
         r.in_set = 1'b1;
         return r;
      end
      mp = root_floor(norm_sq(vr, vi));
      mc = root_floor(norm_sq(zr, zi));
      if (mc > mp && mp < TWO_Q) begin
         frac = ((TWO_Q - mp) << 16) / (mc - mp);
         if (frac > 65535) frac = 65535;
      end
      r.count = iters[15:0];
      r.frac  = frac[15:0];
      return r;
   endfunction

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------- response side ready ----------------
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_cnt  <= hold_len;
         rsp_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else if (gap_cnt > 0) begin
         gap_cnt <= gap_cnt - 1;
         rsp_tready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
         gap_cnt <= $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------- response checker ----------------
   always @(posedge clock) begin
      pix_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.in_set = rsp_tdata[0];
         got.count  = rsp_tdata[16:1];
         got.frac   = rsp_tdata[32:17];
         if (pending_px.size() == 0) begin
            err_count++;
            if (err_count <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            want = pending_px.pop_front();
            if (got !== want) begin
               err_count++;
               if (err_count <= 10)
                  $display({"mismatch: exp inside=%0d count=%0d frac=%0d, ",
                            "got inside=%0d count=%0d frac=%0d"},
                           want.in_set, want.count, want.frac,
                           got.in_set, got.count, got.frac);
            end
         end
      end
   end

   // ---------------- shared tasks ----------------
   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         etfp_pkg::REG_RE_ORIGIN: cfg_re_origin = val;
         etfp_pkg::REG_RE_STEP:   cfg_re_step   = val[30:0];
         etfp_pkg::REG_IM_ORIGIN: cfg_im_origin = val;
         etfp_pkg::REG_IM_STEP:   cfg_im_step   = val[30:0];
         etfp_pkg::REG_ITER_LIM:  cfg_limit     = val[15:0];
         etfp_pkg::REG_KIND:      cfg_kind      = val[1:0];
         etfp_pkg::REG_JULIA_RE:  cfg_julia_re  = val;
         etfp_pkg::REG_JULIA_IM:  cfg_julia_im  = val;
         default: ;
      endcase
   endtask

   task automatic set_view(logic [31:0] reo, logic [31:0] rst, logic [31:0] imo,
                           logic [31:0] ist, logic [31:0] lim, logic [1:0] kind);
      csr_write(etfp_pkg::REG_RE_ORIGIN, reo);
      csr_write(etfp_pkg::REG_RE_STEP, rst);
      csr_write(etfp_pkg::REG_IM_ORIGIN, imo);
      csr_write(etfp_pkg::REG_IM_STEP, ist);
      csr_write(etfp_pkg::REG_ITER_LIM, lim);
      csr_write(etfp_pkg::REG_KIND, {30'd0, kind});
   endtask

   // one pixel request; prediction taken at acceptance
   task automatic send_pixel(logic [11:0] col, logic [11:0] row);
      if (tx_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {row, col};
      do @(posedge clock); while (!req_tready);
      pending_px.push_back(escape_pixel(col, row));
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pending_px.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_random(int n);
      repeat (n) send_pixel(12'($urandom), 12'($urandom));
   endtask

   // ---------------- tests ----------------
   task automatic test_directed();
      // default view corners
      send_pixel(12'd0, 12'd0);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'd0, 12'hFFF);
      send_pixel(12'hFFF, 12'd0);
      send_pixel(12'd1024, 12'd1024);
      wait_drain();
      // Julia escaping before any iteration, then a bounded Julia point
      set_view(32'h0C00_0000, 32'd0, 32'h0C00_0000, 32'd0, 32'd100, etfp_pkg::KIND_JULIA);
      csr_write(etfp_pkg::REG_JULIA_RE, 32'hFD80_0000);
      csr_write(etfp_pkg::REG_JULIA_IM, 32'h0100_0000);
      send_pixel(12'd0, 12'd0);
      wait_drain();
      set_view(32'hFC00_0000, 32'd8192, 32'hFC00_0000, 32'd8192, 32'd60, etfp_pkg::KIND_JULIA);
      send_pixel(12'd512, 12'd512);
      send_pixel(12'hFFF, 12'd7);
      wait_drain();
      // burning ship
      set_view(32'hF800_0000, 32'd49152, 32'hF800_0000, 32'd49152, 32'd80,
               etfp_pkg::KIND_SHIP);
      send_pixel(12'd2000, 12'd1500);
      send_pixel(12'd100, 12'd3000);
      send_pixel(12'd2730, 12'd2730);
      wait_drain();
      // unused kind code
      csr_write(etfp_pkg::REG_KIND, {30'd0, etfp_pkg::KIND_NONE});
      send_pixel(12'd5, 12'd9);
      wait_drain();
      // zero limit and limit of one
      set_view(32'hE000_0000, 32'd524288, 32'hE000_0000, 32'd524288, 32'd0,
               etfp_pkg::KIND_MANDEL);
      send_pixel(12'd3, 12'd4);
      wait_drain();
      csr_write(etfp_pkg::REG_ITER_LIM, 32'd1);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4000, 12'd4000);
      wait_drain();
      // saturating coordinates
      set_view(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd10,
               etfp_pkg::KIND_SHIP);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'd0, 12'd0);
      wait_drain();
      csr_write(etfp_pkg::REG_KIND, {30'd0, etfp_pkg::KIND_MANDEL});
      send_pixel(12'd0, 12'hFFF);
      wait_drain();
   endtask

   task automatic random_config();
      int mode;
      logic [1:0] kind;
      mode = $urandom_range(0, 5);
      kind = ($urandom_range(0, 11) == 0) ? etfp_pkg::KIND_NONE : 2'($urandom_range(0, 2));
      if (mode == 5) begin
         set_view($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 255), kind);
         csr_write(etfp_pkg::REG_JULIA_RE, $urandom);
         csr_write(etfp_pkg::REG_JULIA_IM, $urandom);
      end else begin
         // a view spanning a few units around the interesting region
         set_view(32'($urandom_range(0, 32'h0800_0000)) - 32'h0A00_0000,
                  $urandom_range(0, 32'h0002_0000),
                  32'($urandom_range(0, 32'h0800_0000)) - 32'h0A00_0000,
                  $urandom_range(0, 32'h0002_0000),
                  $urandom_range(1, 150), kind);
         csr_write(etfp_pkg::REG_JULIA_RE,
                   32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000);
         csr_write(etfp_pkg::REG_JULIA_IM,
                   32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000);
      end
   endtask

   task automatic test_random_views();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      repeat (12) begin
         random_config();
         send_random(123);
         wait_drain();
      end
   endtask

   task automatic test_backpressure();
      set_view(32'hF800_0000, 32'd49152, 32'hF800_0000, 32'd49152, 32'd40,
               etfp_pkg::KIND_MANDEL);
      hold_len <= 600;
      hold_seq <= hold_seq + 1;
      send_random(24);
      wait_drain();
      // sender pause until everything is back, then resume
      send_random(6);
      wait_drain();
   endtask

   task automatic test_full_limit();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      set_view(32'd0, 32'd16384, 32'd0, 32'd16384, 32'hFFFF, etfp_pkg::KIND_MANDEL);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd2000, 12'd100);
      wait_drain();
   endtask

   task automatic test_final_burst();
      set_view(32'hF700_0000, 32'd49152, 32'hF700_0000, 32'd49152, 32'd120,
               etfp_pkg::KIND_MANDEL);
      send_random(60);
      wait_drain();
      random_config();
      send_random(60);
      wait_drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_views();
      test_backpressure();
      test_full_limit();
      test_final_burst();
      repeat (20) @(posedge clock);
      if (err_count == 0 && pending_px.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
